FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge walker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, checked through reset as well
`define ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/pew_pkg.sv
// ----------------------------------------------------------------------------
// Polygon edge walker package
// Request codes, internal operation codes, queue sizing and shared types.
// ----------------------------------------------------------------------------
package pew_pkg;

  localparam int COORD_BITS_DEF = 12;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request codes on req_type
  localparam logic [1:0] REQ_LOAD_ONE = 2'd0;
  localparam logic [1:0] REQ_LOAD_TWO = 2'd1;
  localparam logic [1:0] REQ_ADVANCE  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_ONE,
    OP_LOAD_TWO,
    OP_ADVANCE,
    OP_HOLD
  } op_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH,
    ST_EMIT
  } st_t;

endpackage

FILE: rtl/pew_front.sv
// ----------------------------------------------------------------------------
// Edge walker front end
// Accepts request transactions, decodes the request type and queues the
// decoded operation with its vertices for the back end.
// ----------------------------------------------------------------------------
module pew_front
  import pew_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output q_head_t                      head,
  output logic signed [COORD_BITS-1:0] head_ax,
  output logic signed [COORD_BITS-1:0] head_ay,
  output logic signed [COORD_BITS-1:0] head_bx,
  output logic signed [COORD_BITS-1:0] head_by,
  output logic signed [COORD_BITS-1:0] head_cx,
  output logic signed [COORD_BITS-1:0] head_cy,
  input  logic                         pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t                         q_op [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_ax [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_ay [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_bx [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_by [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_cx [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_cy [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;
  op_t              dec_op;

  always_comb begin
    case (req_type)
      REQ_LOAD_ONE: dec_op = OP_LOAD_ONE;
      REQ_LOAD_TWO: dec_op = OP_LOAD_TWO;
      REQ_ADVANCE:  dec_op = OP_ADVANCE;
      default:      dec_op = OP_HOLD;
    endcase
  end

  assign cmd_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign do_pop    = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr] <= dec_op;
      q_ax[wr_ptr] <= ax;
      q_ay[wr_ptr] <= ay;
      q_bx[wr_ptr] <= bx;
      q_by[wr_ptr] <= by;
      q_cx[wr_ptr] <= cx;
      q_cy[wr_ptr] <= cy;
    end
  end

  assign head.valid = (count != '0);
  assign head.op    = q_op[rd_ptr];
  assign head_ax    = q_ax[rd_ptr];
  assign head_ay    = q_ay[rd_ptr];
  assign head_bx    = q_bx[rd_ptr];
  assign head_by    = q_by[rd_ptr];
  assign head_cx    = q_cx[rd_ptr];
  assign head_cy    = q_cy[rd_ptr];

endmodule

FILE: rtl/pew_back.sv
// ----------------------------------------------------------------------------
// Edge walker back end
// Executes queued operations on the edge state: edge setup, scanline step
// with a bit-serial divider for the x run, and the result register.
// ----------------------------------------------------------------------------
module pew_back
  import pew_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  q_head_t                      head,
  input  logic signed [COORD_BITS-1:0] head_ax,
  input  logic signed [COORD_BITS-1:0] head_ay,
  input  logic signed [COORD_BITS-1:0] head_bx,
  input  logic signed [COORD_BITS-1:0] head_by,
  input  logic signed [COORD_BITS-1:0] head_cx,
  input  logic signed [COORD_BITS-1:0] head_cy,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic                         frag_valid,
  output logic signed [COORD_BITS-1:0] frag_x,
  output logic signed [COORD_BITS-1:0] frag_y
);

  localparam int AW    = COORD_BITS + 1;
  localparam int CNT_W = $clog2(AW);

  typedef struct packed {
    logic                  step_left;
    logic [COORD_BITS-1:0] run_len;
    logic [COORD_BITS-1:0] rise_len;
    logic [AW-1:0]         acc;
    logic                  live;
  } edge_t;

  function automatic edge_t setup_f(input logic signed [COORD_BITS-1:0] x0,
                                    input logic signed [COORD_BITS-1:0] y0,
                                    input logic signed [COORD_BITS-1:0] x1,
                                    input logic signed [COORD_BITS-1:0] y1);
    edge_t           e;
    logic [AW-1:0]   dx;
    logic [AW-1:0]   dy;
    dx          = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
    dy          = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
    e.step_left = dx[AW-1];
    e.run_len   = dx[AW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    e.rise_len  = dy[AW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    e.acc       = dx[AW-1] ? AW'(1) : {1'b0, e.rise_len};
    e.live      = (y0 < y1);
    return e;
  endfunction

  st_t state, state_next;

  logic signed [COORD_BITS-1:0] cur_x, cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y, cur_y_next;
  logic signed [COORD_BITS-1:0] end_y, end_y_next;
  logic                         step_left, step_left_next;
  logic [COORD_BITS-1:0]        run_len, run_len_next;
  logic [COORD_BITS-1:0]        rise_len, rise_len_next;
  logic [AW-1:0]                error_acc, error_acc_next;
  logic                         second_pending, second_pending_next;
  logic signed [COORD_BITS-1:0] joint_x, joint_x_next;
  logic signed [COORD_BITS-1:0] joint_y, joint_y_next;
  logic signed [COORD_BITS-1:0] top_x, top_x_next;
  logic signed [COORD_BITS-1:0] top_y, top_y_next;
  logic                         live, live_next;

  logic [AW-1:0]    rem, rem_next;
  logic [AW-1:0]    quo, quo_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic                         out_load;
  edge_t                        e_one;
  edge_t                        e_two;
  edge_t                        e_join;
  logic signed [COORD_BITS-1:0] y_inc;
  logic [AW-1:0]                acc_sum;
  logic [AW-1:0]                rem_shift;
  logic                         rem_ge;

  assign e_one   = setup_f(head_ax, head_ay, head_bx, head_by);
  assign e_two   = setup_f(head_bx, head_by, head_cx, head_cy);
  assign e_join  = setup_f(joint_x, joint_y, top_x, top_y);
  assign y_inc   = cur_y + COORD_BITS'(1);
  assign acc_sum = error_acc + {1'b0, run_len};

  // one restoring-division step: bring in the next dividend bit
  assign rem_shift = {rem[AW-2:0], quo[AW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, rise_len});

  always_comb begin
    state_next          = state;
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    end_y_next          = end_y;
    step_left_next      = step_left;
    run_len_next        = run_len;
    rise_len_next       = rise_len;
    error_acc_next      = error_acc;
    second_pending_next = second_pending;
    joint_x_next        = joint_x;
    joint_y_next        = joint_y;
    top_x_next          = top_x;
    top_y_next          = top_y;
    live_next           = live;
    rem_next            = rem;
    quo_next            = quo;
    cnt_next            = cnt;
    pop                 = 1'b0;
    out_load            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = ST_EMIT;
          case (head.op)
            OP_LOAD_ONE: begin
              second_pending_next = 1'b0;
              joint_x_next        = head_bx;
              joint_y_next        = head_by;
              cur_x_next          = head_ax;
              cur_y_next          = head_ay;
              end_y_next          = head_by;
              step_left_next      = e_one.step_left;
              run_len_next        = e_one.run_len;
              rise_len_next       = e_one.rise_len;
              error_acc_next      = e_one.acc;
              live_next           = e_one.live;
            end
            OP_LOAD_TWO: begin
              joint_x_next = head_bx;
              joint_y_next = head_by;
              top_x_next   = head_cx;
              top_y_next   = head_cy;
              if (e_one.live) begin
                second_pending_next = 1'b1;
                cur_x_next          = head_ax;
                cur_y_next          = head_ay;
                end_y_next          = head_by;
                step_left_next      = e_one.step_left;
                run_len_next        = e_one.run_len;
                rise_len_next       = e_one.rise_len;
                error_acc_next      = e_one.acc;
                live_next           = 1'b1;
              end else begin
                // first edge does not rise: go straight to the second one
                second_pending_next = 1'b0;
                cur_x_next          = head_bx;
                cur_y_next          = head_by;
                end_y_next          = head_cy;
                step_left_next      = e_two.step_left;
                run_len_next        = e_two.run_len;
                rise_len_next       = e_two.rise_len;
                error_acc_next      = e_two.acc;
                live_next           = e_two.live;
              end
            end
            OP_ADVANCE: begin
              if (live) begin
                if (y_inc < end_y) begin
                  cur_y_next = y_inc;
                  if (acc_sum > {1'b0, rise_len}) begin
                    // x moves floor((acc-1)/rise) pixels; divide bit by bit
                    rem_next   = '0;
                    quo_next   = acc_sum - AW'(1);
                    cnt_next   = CNT_W'(AW - 1);
                    state_next = ST_DIVIDE;
                  end else begin
                    error_acc_next = acc_sum;
                  end
                end else if (second_pending) begin
                  second_pending_next = 1'b0;
                  cur_x_next          = joint_x;
                  cur_y_next          = joint_y;
                  end_y_next          = top_y;
                  step_left_next      = e_join.step_left;
                  run_len_next        = e_join.run_len;
                  rise_len_next       = e_join.rise_len;
                  error_acc_next      = e_join.acc;
                  live_next           = e_join.live;
                end else begin
                  cur_y_next = y_inc;
                  live_next  = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIVIDE: begin
        rem_next = rem_ge ? (rem_shift - {1'b0, rise_len}) : rem_shift;
        quo_next = {quo[AW-2:0], rem_ge};
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_FINISH: begin
        error_acc_next = rem + AW'(1);
        cur_x_next     = step_left ? (cur_x - quo[COORD_BITS-1:0])
                                   : (cur_x + quo[COORD_BITS-1:0]);
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register is free or drains this cycle
        if (!res_valid || !res_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cur_x          <= '0;
      cur_y          <= '0;
      end_y          <= '0;
      step_left      <= 1'b0;
      run_len        <= '0;
      rise_len       <= '0;
      error_acc      <= '0;
      second_pending <= 1'b0;
      joint_x        <= '0;
      joint_y        <= '0;
      top_x          <= '0;
      top_y          <= '0;
      live           <= 1'b0;
      cnt            <= '0;
    end else begin
      state          <= state_next;
      cur_x          <= cur_x_next;
      cur_y          <= cur_y_next;
      end_y          <= end_y_next;
      step_left      <= step_left_next;
      run_len        <= run_len_next;
      rise_len       <= rise_len_next;
      error_acc      <= error_acc_next;
      second_pending <= second_pending_next;
      joint_x        <= joint_x_next;
      joint_y        <= joint_y_next;
      top_x          <= top_x_next;
      top_y          <= top_y_next;
      live           <= live_next;
      cnt            <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    quo <= quo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frag_valid <= live;
      frag_x     <= live ? cur_x : '0;
      frag_y     <= live ? cur_y : '0;
    end
  end

endmodule

FILE: rtl/polygon_edge_walker.sv
// Flow: a load or a step that leaves x alone passes IDLE, EMIT and the result
//   register; a step that moves x first adds the serial divide (DIVIDE, FINISH).
// Order: the back end takes one item at a time and pops the next only after EMIT
//   has loaded the result register, which waits while a held result is stalled.
// Reset: rst is synchronous; clears the queue, edge state (no fragment) and result.
// ----------------------------------------------------------------------------
// Polygon edge walker
// Integer DDA edge walker with decoupled request decode and edge execution.
// ----------------------------------------------------------------------------
module polygon_edge_walker
  import pew_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic                         frag_valid,
  output logic signed [COORD_BITS-1:0] frag_x,
  output logic signed [COORD_BITS-1:0] frag_y
);

  q_head_t                      head;
  logic signed [COORD_BITS-1:0] head_ax;
  logic signed [COORD_BITS-1:0] head_ay;
  logic signed [COORD_BITS-1:0] head_bx;
  logic signed [COORD_BITS-1:0] head_by;
  logic signed [COORD_BITS-1:0] head_cx;
  logic signed [COORD_BITS-1:0] head_cy;
  logic                         pop;

  pew_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .req_type  (req_type),
    .ax        (ax),
    .ay        (ay),
    .bx        (bx),
    .by        (by),
    .cx        (cx),
    .cy        (cy),
    .head      (head),
    .head_ax   (head_ax),
    .head_ay   (head_ay),
    .head_bx   (head_bx),
    .head_by   (head_by),
    .head_cx   (head_cx),
    .head_cy   (head_cy),
    .pop       (pop)
  );

  pew_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_ax    (head_ax),
    .head_ay    (head_ay),
    .head_bx    (head_bx),
    .head_by    (head_by),
    .head_cx    (head_cx),
    .head_cy    (head_cy),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .frag_valid (frag_valid),
    .frag_x     (frag_x),
    .frag_y     (frag_y)
  );

endmodule

FILE: rtl/pew_checker.sv
// ----------------------------------------------------------------------------
// Edge walker port checker
// Watches the result channel of the edge walker over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pew_checker
  import pew_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic                         frag_valid,
  input logic signed [COORD_BITS-1:0] frag_x,
  input logic signed [COORD_BITS-1:0] frag_y
);

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(frag_x) && $stable(frag_y) && $stable(frag_valid), "stalled result changed")
  `ASSERT_IMPLY(a_no_frag_zero, clk, rst, res_valid && !frag_valid, frag_x == '0 && frag_y == '0, "invalid fragment with nonzero coordinates")
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !res_valid, "result present right after reset")

endmodule

bind polygon_edge_walker pew_checker #(.COORD_BITS(COORD_BITS)) u_pew_checker (.*);
